FILE: sv/sce_pkg.sv
// sce_pkg: shared types and constants for the servo command frame encoder.
// Used by sce_front, sce_queue, sce_back and the top level; no dependencies.
`default_nettype none

package sce_pkg;

  // command ops
  localparam logic [1:0] OP_SPEED   = 2'd0;
  localparam logic [1:0] OP_POS_INV = 2'd1;
  localparam logic [1:0] OP_POS     = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  // packet fields
  localparam logic [7:0] HEADER_BYTE   = 8'hFF;
  localparam logic [7:0] LEN_SPEED     = 8'd5;
  localparam logic [7:0] LEN_POS       = 8'd9;
  localparam logic [7:0] LEN_READ      = 8'd4;
  localparam logic [7:0] INSTR_WRITE   = 8'd3;
  localparam logic [7:0] INSTR_READ    = 8'd2;
  localparam logic [7:0] ADDR_SPEED    = 8'd46;
  localparam logic [7:0] ADDR_POS      = 8'd42;
  localparam logic [7:0] ADDR_PRESENT  = 8'd56;
  localparam logic [7:0] READ_COUNT    = 8'd2;

  // byte positions within a packet
  localparam logic [3:0] BYTE_ID       = 4'd2;
  localparam logic [3:0] BYTE_LEN      = 4'd3;
  localparam logic [3:0] BYTE_INSTR    = 4'd4;
  localparam logic [3:0] BYTE_ADDR     = 4'd5;
  localparam logic [3:0] BYTE_D0       = 4'd6;
  localparam logic [3:0] BYTE_D1       = 4'd7;
  localparam logic [3:0] BYTE_D2       = 4'd8;
  localparam logic [3:0] BYTE_D3       = 4'd9;
  localparam logic [3:0] BYTE_D4       = 4'd10;
  localparam logic [3:0] BYTE_D5       = 4'd11;
  localparam logic [3:0] LAST_SPEED    = 4'd8;
  localparam logic [3:0] LAST_POS      = 4'd12;
  localparam logic [3:0] LAST_READ     = 4'd7;

  // speed profile
  localparam logic [15:0] DEAD_BAND    = 16'd10;
  localparam logic [12:0] THR_SCALE    = 13'd6000;
  localparam logic [10:0] RAD_SCALE    = 11'd1500;
  localparam logic [15:0] POS_INVERT   = 16'd4095;
  localparam logic [2:0]  SQRT_LAST    = 3'd6;   // index of the last root step; two root bits per step

  localparam logic [7:0]  SERVO_ID_RESET = 8'd1;

  localparam int unsigned Q_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] word;   // speed word (op 0) or position word (ops 1, 2)
    logic [15:0] spd;
  } sce_cmd_t;

endpackage

`default_nettype wire

FILE: sv/sce_front.sv
// sce_front: accepts commands, works out the speed/position data word.
// Three stages plus an iterative square root; depends on sce_pkg.
`default_nettype none

module sce_front import sce_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_op,
  input  wire logic [14:0]        in_speed_limit,
  input  wire logic signed [15:0] in_move_speed,
  input  wire logic signed [15:0] in_goal_position,
  input  wire logic signed [15:0] in_current_position,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output sce_cmd_t                push_data
);

  logic s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt, s3_v_r, s3_v_nxt;
  logic busy_r, busy_nxt;
  logic s3_done, s3_free, s2_free, in_acc, s2_load, s3_load;

  // stage 1
  logic [1:0]  s1_op_r;
  logic [14:0] s1_lim_r;
  logic [15:0] s1_spd_r, s1_pos_r, s1_diff_r;
  logic        s1_neg_r;
  logic signed [16:0] d_in;
  logic [16:0] d_abs;

  // stage 2
  logic [1:0]  s2_op_r;
  logic [14:0] s2_lim_r;
  logic [15:0] s2_spd_r, s2_pos_r;
  logic        s2_neg_r, s2_small_r;
  logic [29:0] s2_lsq_r, s2_thr_r;
  logic [26:0] s2_rad_r;

  // stage 3 / square root
  logic [1:0]  s3_op_r;
  logic [15:0] s3_spd_r, s3_word_r;
  logic        s3_neg_r;
  logic [27:0] rad_sh_r;
  logic [16:0] rem_r, rem_a, rem_b, rem_c, rem_d, trial_a, trial_c;
  logic [13:0] root_r, root_b, root_d;
  logic [2:0]  cnt_r;

  assign s3_done    = s3_v_r && !busy_r;
  assign s3_free    = !s3_v_r || (s3_done && push_ready);
  assign s2_free    = !s2_v_r || s3_free;
  assign in_ready   = !s1_v_r || s2_free;
  assign in_acc     = in_valid && in_ready;
  assign s2_load    = s1_v_r && s2_free;
  assign s3_load    = s2_v_r && s3_free;
  assign push_valid = s3_done;
  assign push_data  = '{op: s3_op_r, word: s3_word_r, spd: s3_spd_r};

  assign s1_v_nxt = in_acc || (s1_v_r && !s2_free);
  assign s2_v_nxt = s2_load || (s2_v_r && !s3_free);
  assign s3_v_nxt = s3_load || (s3_v_r && !(s3_done && push_ready));

  always_comb begin
    busy_nxt = busy_r;
    if (s3_load) begin
      busy_nxt = (s2_op_r == OP_SPEED) && !s2_small_r && (s2_lsq_r >= s2_thr_r);
    end else if (busy_r && cnt_r == SQRT_LAST) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign d_in  = {in_goal_position[15], in_goal_position}
               - {in_current_position[15], in_current_position};
  assign d_abs = d_in[16] ? 17'(-d_in) : 17'(d_in);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_op;
      s1_lim_r  <= in_speed_limit;
      s1_spd_r  <= in_move_speed;
      s1_pos_r  <= (in_op == OP_POS_INV) ? 16'(POS_INVERT - in_goal_position)
                                         : in_goal_position;
      s1_diff_r <= d_abs[15:0];
      s1_neg_r  <= !d_in[16] && (d_in != 17'sd0);
    end
  end

  // products registered before any compare
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_op_r    <= s1_op_r;
      s2_lim_r   <= s1_lim_r;
      s2_spd_r   <= s1_spd_r;
      s2_pos_r   <= s1_pos_r;
      s2_neg_r   <= s1_neg_r;
      s2_small_r <= s1_diff_r < DEAD_BAND;
      s2_lsq_r   <= 30'(s1_lim_r * s1_lim_r);
      // diff < floor(lim^2/6000)  <=>  lim^2 >= 6000*(diff+1)
      s2_thr_r   <= 30'(({1'b0, s1_diff_r} + 17'd1) * THR_SCALE);
      s2_rad_r   <= 27'(s1_diff_r * RAD_SCALE);
    end
  end

  // two restoring root steps per cycle
  always_comb begin
    rem_a   = {rem_r[14:0], rad_sh_r[27:26]};
    trial_a = {1'b0, root_r, 2'b01};
    if (rem_a >= trial_a) begin
      rem_b  = rem_a - trial_a;
      root_b = {root_r[12:0], 1'b1};
    end else begin
      rem_b  = rem_a;
      root_b = {root_r[12:0], 1'b0};
    end
    rem_c   = {rem_b[14:0], rad_sh_r[25:24]};
    trial_c = {1'b0, root_b, 2'b01};
    if (rem_c >= trial_c) begin
      rem_d  = rem_c - trial_c;
      root_d = {root_b[12:0], 1'b1};
    end else begin
      rem_d  = rem_c;
      root_d = {root_b[12:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_op_r  <= s2_op_r;
      s3_spd_r <= s2_spd_r;
      s3_neg_r <= s2_neg_r;
      rad_sh_r <= {1'b0, s2_rad_r};
      rem_r    <= '0;
      root_r   <= '0;
      cnt_r    <= '0;
      if (s2_op_r != OP_SPEED) begin
        s3_word_r <= s2_pos_r;
      end else if (s2_small_r || s2_lim_r == 15'd0) begin
        s3_word_r <= '0;
      end else begin
        s3_word_r <= {s2_neg_r, s2_lim_r};
      end
    end else if (busy_r) begin
      rad_sh_r <= {rad_sh_r[23:0], 4'b0000};
      rem_r    <= rem_d;
      root_r   <= root_d;
      cnt_r    <= cnt_r + 3'd1;
      if (cnt_r == SQRT_LAST) begin
        s3_word_r <= {s3_neg_r, 1'b0, root_d};
      end
    end
  end

  a_busy_valid: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> s3_v_r)
    else $error("root unit running without an item");

  a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == SQRT_LAST) |=> !busy_r)
    else $error("root unit overran");

  a_no_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> !push_valid)
    else $error("push during root start");

endmodule

`default_nettype wire

FILE: sv/sce_queue.sv
// sce_queue: two-entry command queue between front and back.
// Depends on sce_pkg for the entry type and depth.
`default_nettype none

module sce_queue import sce_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire sce_cmd_t push_data,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output sce_cmd_t      pop_data
);

  sce_cmd_t   ent_r [Q_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = cnt_r != 2'(Q_DEPTH);
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_data   = ent_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  assign wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
  assign cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'(Q_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers out of step with count");

  a_cnt_move: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count missed a push");

endmodule

`default_nettype wire

FILE: sv/sce_back.sv
// sce_back: serialises one queued command into its packet, byte by byte,
// with a running checksum. Depends on sce_pkg.
`default_nettype none

module sce_back import sce_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] servo_id,
  input  wire logic       pop_valid,
  output logic            pop_ready,
  input  wire sce_cmd_t   pop_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  sce_cmd_t   cmd_r;
  logic       busy_r, busy_nxt;
  logic [3:0] idx_r, last_idx;
  logic [7:0] sum_r, body;
  logic       xfer;

  always_comb begin
    case (cmd_r.op)
      OP_SPEED: last_idx = LAST_SPEED;
      OP_READ:  last_idx = LAST_READ;
      default:  last_idx = LAST_POS;
    endcase
  end

  always_comb begin
    case (idx_r)
      BYTE_ID:    body = servo_id;
      BYTE_LEN:   body = (cmd_r.op == OP_SPEED) ? LEN_SPEED :
                         (cmd_r.op == OP_READ)  ? LEN_READ  : LEN_POS;
      BYTE_INSTR: body = (cmd_r.op == OP_READ) ? INSTR_READ : INSTR_WRITE;
      BYTE_ADDR:  body = (cmd_r.op == OP_SPEED) ? ADDR_SPEED :
                         (cmd_r.op == OP_READ)  ? ADDR_PRESENT : ADDR_POS;
      BYTE_D0:    body = (cmd_r.op == OP_READ) ? READ_COUNT : cmd_r.word[7:0];
      BYTE_D1:    body = cmd_r.word[15:8];
      BYTE_D2:    body = 8'h00;
      BYTE_D3:    body = 8'h00;
      BYTE_D4:    body = cmd_r.spd[7:0];
      BYTE_D5:    body = cmd_r.spd[15:8];
      default:    body = HEADER_BYTE;
    endcase
  end

  assign out_valid = busy_r;
  assign out_last  = idx_r == last_idx;
  assign out_byte  = out_last ? ~sum_r : body;
  assign xfer      = out_valid && out_ready;
  assign pop_ready = !busy_r || (xfer && out_last);
  assign busy_nxt  = pop_ready ? pop_valid : busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // checksum covers id up to the last data byte
  always_ff @(posedge clk) begin
    if (pop_ready) begin
      cmd_r <= pop_data;
      idx_r <= '0;
      sum_r <= '0;
    end else if (xfer) begin
      idx_r <= idx_r + 4'd1;
      if (idx_r >= BYTE_ID) begin
        sum_r <= sum_r + body;
      end
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= last_idx)
    else $error("byte index past end of packet");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_ready) |=> ($stable(idx_r) && $stable(sum_r)))
    else $error("packet advanced while stalled");

endmodule

`default_nettype wire

FILE: sv/servo_command_frame_encoder_core.sv
// servo_command_frame_encoder_core: top level, id register and wiring of
// front, queue and back. Depends on sce_pkg, sce_front, sce_queue, sce_back.
//
//   channel | ports                                  | role
//   in      | in_valid/in_ready, in_op .. in_current | one command per transfer
//   out     | out_valid/out_ready, out_byte, out_last| one packet byte per transfer
//   cfg     | cfg_valid/cfg_ready, cfg_data          | servo id write, always ready
//
// Packets are 8 (read), 9 (speed) or 13 (position write) bytes, one byte per
// cycle while out_ready is high; the next queued command is popped as the last
// byte transfers. Square-root speed moves pass through the root unit (two root
// bits per cycle); the first byte follows the front stages, the queue entry and
// the serialiser's command register. A two-entry queue lets front and back
// stall independently. Synchronous active-low reset; the servo id resets to 1.
`default_nettype none

module servo_command_frame_encoder_core import sce_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_op,
  input  wire logic [14:0]        in_speed_limit,
  input  wire logic signed [15:0] in_move_speed,
  input  wire logic signed [15:0] in_goal_position,
  input  wire logic signed [15:0] in_current_position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data
);

  logic [7:0] servo_id_r, servo_id_nxt;
  logic       f_valid, f_ready, b_valid, b_ready;
  sce_cmd_t   f_data, b_data;

  assign cfg_ready    = 1'b1;
  assign servo_id_nxt = (cfg_valid && cfg_ready) ? cfg_data : servo_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_id_r <= SERVO_ID_RESET;
    end else begin
      servo_id_r <= servo_id_nxt;
    end
  end

  sce_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_speed_limit      (in_speed_limit),
    .in_move_speed       (in_move_speed),
    .in_goal_position    (in_goal_position),
    .in_current_position (in_current_position),
    .push_valid          (f_valid),
    .push_ready          (f_ready),
    .push_data           (f_data)
  );

  sce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  sce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .servo_id  (servo_id_r),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire
